// File: rtl/core/hsal_pkg.sv
// hsal_pkg: shared types, command codes and quadrature tables for the
// hermite spline arc length unit; no dependencies
package hsal_pkg;

  localparam int NODE_FRAC  = 24;
  localparam int NUM_NODES  = 5;
  localparam int COEF_W     = 37;
  localparam int MAG_W      = 40;
  localparam int CHUNK_W    = 20;
  localparam int PROD_W     = 44;
  localparam int ACC_W      = 64;
  localparam int SQ_W       = 80;
  localparam int ROOT_W     = 40;
  localparam int REM_W      = 42;

  // datapath operations
  localparam logic [3:0] OP_NOP     = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;
  localparam logic [3:0] OP_LD_C1   = 4'd2;
  localparam logic [3:0] OP_MUL     = 4'd3;
  localparam logic [3:0] OP_ADD     = 4'd4;
  localparam logic [3:0] OP_RND_C2  = 4'd5;
  localparam logic [3:0] OP_RND_C3  = 4'd6;
  localparam logic [3:0] OP_RT_INIT = 4'd7;
  localparam logic [3:0] OP_RT_STEP = 4'd8;
  localparam logic [3:0] OP_RT_FIN  = 4'd9;
  localparam logic [3:0] OP_FINISH  = 4'd10;

  // multiplier b operand
  localparam logic [1:0] B_NODE = 2'd0;
  localparam logic [1:0] B_WGT  = 2'd1;
  localparam logic [1:0] B_MLO  = 2'd2;
  localparam logic [1:0] B_MHI  = 2'd3;

  // accumulate destinations
  localparam logic [1:0] D_ACC = 2'd0;
  localparam logic [1:0] D_SQ  = 2'd1;
  localparam logic [1:0] D_WS  = 2'd2;

  // accumulate shifts
  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_20 = 2'd1;
  localparam logic [1:0] SH_21 = 2'd2;
  localparam logic [1:0] SH_40 = 2'd3;

  typedef struct packed {
    logic [3:0] op;
    logic       a_hi;
    logic [1:0] b_sel;
    logic [1:0] dst;
    logic [1:0] sh;
    logic [1:0] axis;
    logic [2:0] node;
  } hsal_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic out_free;
  } hsal_stat_t;

  function automatic logic [23:0] node_a(input logic [2:0] idx);
    logic [23:0] v;
    unique case (idx)
      3'd0:    v = 24'd8388608;
      3'd1:    v = 24'd3871600;
      3'd2:    v = 24'd12905616;
      3'd3:    v = 24'd787020;
      3'd4:    v = 24'd15990196;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [23:0] node_w(input logic [2:0] idx);
    logic [23:0] v;
    unique case (idx)
      3'd0:    v = 24'd9544372;
      3'd1:    v = 24'd8030057;
      3'd2:    v = 24'd8030057;
      3'd3:    v = 24'd3974973;
      3'd4:    v = 24'd3974973;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/hsal_in_if.sv
// hsal_in_if: control point channel with valid/ready handshake
// no dependencies
interface hsal_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] loc_x;
  logic signed [31:0] loc_y;
  logic signed [31:0] loc_z;
  logic signed [31:0] arrive_x;
  logic signed [31:0] arrive_y;
  logic signed [31:0] arrive_z;
  logic signed [31:0] leave_x;
  logic signed [31:0] leave_y;
  logic signed [31:0] leave_z;
  logic               end_of_spline;

  modport source (output valid, loc_x, loc_y, loc_z, arrive_x, arrive_y, arrive_z,
                  leave_x, leave_y, leave_z, end_of_spline, input ready);
  modport sink (input valid, loc_x, loc_y, loc_z, arrive_x, arrive_y, arrive_z,
                leave_x, leave_y, leave_z, end_of_spline, output ready);
endinterface

// File: rtl/core/hsal_out_if.sv
// hsal_out_if: segment length result channel with valid/ready handshake
// no dependencies
interface hsal_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] segment_length;
  logic [47:0] total_length;
  logic        final_segment;

  modport source (output valid, segment_length, total_length, final_segment, input ready);
  modport sink (input valid, segment_length, total_length, final_segment, output ready);
endinterface

// File: rtl/core/hsal_ctrl.sv
// hsal_ctrl: sequencer that walks nodes, axes, root steps and weighting
// depends on hsal_pkg
module hsal_ctrl
  import hsal_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  hsal_stat_t stat,
  output hsal_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_AXIS = 3'd1;
  localparam logic [2:0] ST_SQRT = 3'd2;
  localparam logic [2:0] ST_WGT  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam logic [5:0] AXIS_LAST = 6'd16;
  localparam logic [5:0] SQRT_LAST = 6'd41;
  localparam logic [5:0] WGT_LAST  = 6'd3;
  localparam logic [2:0] NODE_LAST = 3'(NUM_NODES - 1);

  logic [2:0] state_r, state_nxt;
  logic [5:0] step_r, step_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [2:0] node_r, node_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    axis_nxt  = axis_r;
    node_nxt  = node_r;
    cmd       = '0;
    cmd.op    = OP_NOP;
    cmd.axis  = axis_r;
    cmd.node  = node_r;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        axis_nxt = '0;
        node_nxt = '0;
        if (in_valid) begin
          cmd.op = OP_LOAD;
          if (stat.have_prev) state_nxt = ST_AXIS;
        end
      end
      ST_AXIS: begin
        unique case (step_r)
          6'd0:           cmd.op = OP_LD_C1;
          6'd1, 6'd6:     begin cmd.op = OP_MUL; cmd.b_sel = B_NODE; end
          6'd2, 6'd7:     begin cmd.op = OP_ADD; cmd.dst = D_ACC; cmd.sh = SH_0; end
          6'd3, 6'd8:     begin cmd.op = OP_MUL; cmd.a_hi = 1'b1; cmd.b_sel = B_NODE; end
          6'd4, 6'd9:     begin cmd.op = OP_ADD; cmd.dst = D_ACC; cmd.sh = SH_20; end
          6'd5:           cmd.op = OP_RND_C2;
          6'd10:          cmd.op = OP_RND_C3;
          6'd11:          begin cmd.op = OP_MUL; cmd.b_sel = B_MLO; end
          6'd12:          begin cmd.op = OP_ADD; cmd.dst = D_SQ; cmd.sh = SH_0; end
          6'd13:          begin cmd.op = OP_MUL; cmd.b_sel = B_MHI; end
          6'd14:          begin cmd.op = OP_ADD; cmd.dst = D_SQ; cmd.sh = SH_21; end
          6'd15:          begin cmd.op = OP_MUL; cmd.a_hi = 1'b1; cmd.b_sel = B_MHI; end
          6'd16:          begin cmd.op = OP_ADD; cmd.dst = D_SQ; cmd.sh = SH_40; end
          default:        cmd.op = OP_NOP;
        endcase
        if (step_r == AXIS_LAST) begin
          step_nxt = '0;
          if (axis_r == 2'd2) begin
            axis_nxt  = '0;
            state_nxt = ST_SQRT;
          end else begin
            axis_nxt = axis_r + 2'd1;
          end
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      ST_SQRT: begin
        if (step_r == 6'd0) cmd.op = OP_RT_INIT;
        else if (step_r == SQRT_LAST) cmd.op = OP_RT_FIN;
        else cmd.op = OP_RT_STEP;
        if (step_r == SQRT_LAST) begin
          step_nxt  = '0;
          state_nxt = ST_WGT;
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      ST_WGT: begin
        cmd.op    = step_r[0] ? OP_ADD : OP_MUL;
        cmd.a_hi  = step_r[1];
        cmd.b_sel = B_WGT;
        cmd.dst   = D_WS;
        cmd.sh    = step_r[1] ? SH_20 : SH_0;
        if (step_r == WGT_LAST) begin
          step_nxt = '0;
          if (node_r == NODE_LAST) begin
            state_nxt = ST_FIN;
          end else begin
            node_nxt  = node_r + 3'd1;
            state_nxt = ST_AXIS;
          end
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.op    = OP_FINISH;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      axis_r  <= '0;
      node_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      axis_r  <= axis_nxt;
      node_r  <= node_nxt;
    end
  end

endmodule

// File: rtl/core/hsal_datapath.sv
// hsal_datapath: coefficients, shared 20x24 multiplier, accumulators,
// bit-serial square root and output register; depends on hsal_pkg
module hsal_datapath
  import hsal_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  hsal_cmd_t          cmd,
  output hsal_stat_t         stat,
  input  logic signed [31:0] loc_x,
  input  logic signed [31:0] loc_y,
  input  logic signed [31:0] loc_z,
  input  logic signed [31:0] arrive_x,
  input  logic signed [31:0] arrive_y,
  input  logic signed [31:0] arrive_z,
  input  logic signed [31:0] leave_x,
  input  logic signed [31:0] leave_y,
  input  logic signed [31:0] leave_z,
  input  logic               end_of_spline,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [31:0]        segment_length,
  output logic [47:0]        total_length,
  output logic               final_segment
);

  logic signed [31:0] p1 [3];
  logic signed [31:0] t1 [3];
  logic signed [31:0] lv [3];

  logic signed [31:0]       prev_loc_r [3];
  logic signed [31:0]       prev_lv_r  [3];
  logic signed [31:0]       new_loc_r  [3];
  logic signed [31:0]       new_lv_r   [3];
  logic signed [COEF_W-1:0] c1_r [3];
  logic signed [COEF_W-1:0] c2_r [3];
  logic signed [31:0]       c3_r [3];
  logic                     have_prev_r;
  logic                     last_r;
  logic [47:0]              total_r;

  logic              neg_r;
  logic [MAG_W-1:0]  mag_r;
  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  acc_r;
  logic [SQ_W-1:0]   sq_r;
  logic [SQ_W-1:0]   rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [ACC_W-1:0]  ws_r;

  logic        out_valid_r;
  logic [31:0] seg_out_r;
  logic [47:0] tot_out_r;
  logic        fin_out_r;

  assign p1 = '{loc_x, loc_y, loc_z};
  assign t1 = '{arrive_x, arrive_y, arrive_z};
  assign lv = '{leave_x, leave_y, leave_z};

  assign stat.have_prev = have_prev_r;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign segment_length = seg_out_r;
  assign total_length   = tot_out_r;
  assign final_segment  = fin_out_r;

  // derivative coefficients from kept point and incoming point
  logic signed [COEF_W-1:0] c1_nxt [3];
  logic signed [COEF_W-1:0] c2_nxt [3];

  always_comb begin
    logic signed [COEF_W-1:0] d, s, e0, e1;
    for (int k = 0; k < 3; k++) begin
      d  = COEF_W'(prev_loc_r[k]) - COEF_W'(p1[k]);
      e0 = COEF_W'(prev_lv_r[k]);
      e1 = COEF_W'(t1[k]);
      s  = (d <<< 1) + e0 + e1;
      c1_nxt[k] = s + (s <<< 1);
      c2_nxt[k] = -((d <<< 2) + (d <<< 1)) - (e0 <<< 2) - (e1 <<< 1);
    end
  end

  // shared multiplier operands
  logic [CHUNK_W-1:0] mul_a;
  logic [23:0]        mul_b;
  logic [PROD_W-1:0]  prod_nxt;

  always_comb begin
    mul_a = cmd.a_hi ? mag_r[MAG_W-1:CHUNK_W] : mag_r[CHUNK_W-1:0];
    unique case (cmd.b_sel)
      B_NODE:  mul_b = node_a(cmd.node);
      B_WGT:   mul_b = node_w(cmd.node);
      B_MLO:   mul_b = {4'b0, mag_r[CHUNK_W-1:0]};
      B_MHI:   mul_b = {4'b0, mag_r[MAG_W-1:CHUNK_W]};
      default: mul_b = '0;
    endcase
    prod_nxt = {24'b0, mul_a} * {20'b0, mul_b};
  end

  // shifted product for accumulation
  logic [SQ_W-1:0] addend;

  always_comb begin
    unique case (cmd.sh)
      SH_0:    addend = SQ_W'(prod_r);
      SH_20:   addend = SQ_W'(prod_r) << 20;
      SH_21:   addend = SQ_W'(prod_r) << 21;
      SH_40:   addend = SQ_W'(prod_r) << 40;
      default: addend = '0;
    endcase
  end

  // round the node product and add the next coefficient
  logic [ACC_W-1:0]        acc_rnd;
  logic signed [MAG_W:0]   rnd_val;
  logic signed [MAG_W:0]   rnd_sum;
  logic [MAG_W-1:0]        rnd_mag;

  always_comb begin
    acc_rnd = (acc_r + (ACC_W'(1) << (NODE_FRAC - 1))) >> NODE_FRAC;
    rnd_val = neg_r ? -$signed({1'b0, acc_rnd[MAG_W-1:0]})
                    : $signed({1'b0, acc_rnd[MAG_W-1:0]});
    if (cmd.op == OP_RND_C2)
      rnd_sum = rnd_val + (MAG_W + 1)'(c2_r[cmd.axis]);
    else
      rnd_sum = rnd_val + (MAG_W + 1)'(c3_r[cmd.axis]);
    rnd_mag = rnd_sum[MAG_W] ? MAG_W'(-rnd_sum) : rnd_sum[MAG_W-1:0];
  end

  // one root digit per cycle
  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             take;

  always_comb begin
    rem_sh = {rem_r, rad_r[SQ_W-1:SQ_W-2]};
    trial  = (REM_W + 2)'({root_r, 2'b01});
    take   = (rem_sh >= trial);
  end

  // final rounding of the weighted sum
  logic [ACC_W:0] ws_rnd;
  logic [ACC_W-NODE_FRAC-1:0] seg_full;
  logic [31:0]    seg_sat;
  logic [48:0]    tot_sum;
  logic [47:0]    tot_sat;

  always_comb begin
    ws_rnd   = {1'b0, ws_r} + (ACC_W + 1)'(1 << NODE_FRAC);
    seg_full = ws_rnd[ACC_W:NODE_FRAC + 1];
    seg_sat  = (|seg_full[ACC_W-NODE_FRAC-1:32]) ? 32'hFFFF_FFFF : seg_full[31:0];
    tot_sum  = {1'b0, total_r} + {17'b0, seg_sat};
    tot_sat  = tot_sum[48] ? 48'hFFFF_FFFF_FFFF : tot_sum[47:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        prev_loc_r[k] <= '0;
        prev_lv_r[k]  <= '0;
      end
    end else begin
      if (cmd.op == OP_FINISH) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (cmd.op)
        OP_LOAD: begin
          if (!have_prev_r && !end_of_spline) begin
            have_prev_r <= 1'b1;
            for (int k = 0; k < 3; k++) begin
              prev_loc_r[k] <= p1[k];
              prev_lv_r[k]  <= lv[k];
            end
          end
        end
        OP_FINISH: begin
          if (last_r) begin
            have_prev_r <= 1'b0;
            total_r     <= '0;
            for (int k = 0; k < 3; k++) begin
              prev_loc_r[k] <= '0;
              prev_lv_r[k]  <= '0;
            end
          end else begin
            total_r <= tot_sat;
            for (int k = 0; k < 3; k++) begin
              prev_loc_r[k] <= new_loc_r[k];
              prev_lv_r[k]  <= new_lv_r[k];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        for (int k = 0; k < 3; k++) begin
          c1_r[k]      <= c1_nxt[k];
          c2_r[k]      <= c2_nxt[k];
          c3_r[k]      <= prev_lv_r[k];
          new_loc_r[k] <= p1[k];
          new_lv_r[k]  <= lv[k];
        end
        last_r <= end_of_spline;
        sq_r   <= '0;
        ws_r   <= '0;
      end
      OP_LD_C1: begin
        neg_r <= c1_r[cmd.axis][COEF_W-1];
        mag_r <= c1_r[cmd.axis][COEF_W-1] ? MAG_W'(-c1_r[cmd.axis])
                                          : MAG_W'(c1_r[cmd.axis]);
        acc_r <= '0;
      end
      OP_MUL: prod_r <= prod_nxt;
      OP_ADD: begin
        unique case (cmd.dst)
          D_ACC:   acc_r <= acc_r + addend[ACC_W-1:0];
          D_SQ:    sq_r  <= sq_r + addend;
          D_WS:    ws_r  <= ws_r + addend[ACC_W-1:0];
          default: ;
        endcase
      end
      OP_RND_C2, OP_RND_C3: begin
        neg_r <= rnd_sum[MAG_W];
        mag_r <= rnd_mag;
        acc_r <= '0;
      end
      OP_RT_INIT: begin
        rad_r  <= sq_r;
        sq_r   <= '0;
        rem_r  <= '0;
        root_r <= '0;
      end
      OP_RT_STEP: begin
        rad_r  <= rad_r << 2;
        rem_r  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        root_r <= {root_r[ROOT_W-2:0], take};
      end
      OP_RT_FIN: begin
        // round to nearest
        mag_r <= (rem_r > REM_W'(root_r)) ? root_r + ROOT_W'(1) : root_r;
      end
      OP_FINISH: begin
        seg_out_r <= seg_sat;
        tot_out_r <= tot_sat;
        fin_out_r <= last_r;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/hermite_spline_arc_length_unit.sv
// hermite_spline_arc_length_unit: top level, joins sequencer and datapath
// depends on hsal_pkg, hsal_in_if, hsal_out_if, hsal_ctrl, hsal_datapath
// a segment-closing point is worked through node by node: per node three axes,
//   a square root and a weighting step, then a finish step that waits while
//   the previous result waits; a first point is only kept and gives no result
// a new point is taken only while idle, so the pace is set by the single shared
//   20x24 multiplier and the one-digit-per-cycle square root, run 5 times
// reset: synchronous active-low rst_n clears the kept point, total and control
module hermite_spline_arc_length_unit
  import hsal_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  hsal_in_if.sink    in_chan,
  hsal_out_if.source out_chan
);

  hsal_cmd_t  cmd;
  hsal_stat_t stat;

  hsal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hsal_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .loc_x          (in_chan.loc_x),
    .loc_y          (in_chan.loc_y),
    .loc_z          (in_chan.loc_z),
    .arrive_x       (in_chan.arrive_x),
    .arrive_y       (in_chan.arrive_y),
    .arrive_z       (in_chan.arrive_z),
    .leave_x        (in_chan.leave_x),
    .leave_y        (in_chan.leave_y),
    .leave_z        (in_chan.leave_z),
    .end_of_spline  (in_chan.end_of_spline),
    .out_ready      (out_chan.ready),
    .out_valid      (out_chan.valid),
    .segment_length (out_chan.segment_length),
    .total_length   (out_chan.total_length),
    .final_segment  (out_chan.final_segment)
  );

endmodule
